@@ hw/rtl/oledser_pkg.sv @@
// ----------------------------------------------------------------------------
// oledser_pkg
// Shared types, codes and helpers for the OLED I2C write serializer.
// ----------------------------------------------------------------------------
package oledser_pkg;

   localparam int BYTES_PER_FRAME = 3;
   localparam int FRAME_W         = 8 * BYTES_PER_FRAME;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [7:0] ADDR_RESET  = 8'h78;
   localparam logic [7:0] DELAY_RESET = 8'd10;
   localparam logic [7:0] CTRL_CMD    = 8'h00;
   localparam logic [7:0] CTRL_DATA   = 8'h40;

   // request operation codes
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_CMD   = 2'd1,
      OP_DATA  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   // configuration register indexes
   typedef enum logic {
      CSR_DEVICE_ADDRESS = 1'b0,
      CSR_DELAY_TICKS    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] payload;
   } req_data_type;

   typedef struct packed {
      logic scl_level;
      logic sda_level;
      logic busy_res;
      logic done_res;
      logic rejected;
   } rsp_data_type;

   // classified queue entry
   typedef struct packed {
      logic       start_req;
      logic       is_data;
      logic [7:0] payload;
   } qent_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      qent_type ent;
   } qhead_type;

   // bit to put on SDA for byte bn, bit bt (MSB first)
   function automatic logic frame_bit(input logic [FRAME_W-1:0] frame,
                                      input logic [1:0] bn,
                                      input logic [2:0] bt);
      logic [1:0] bsel;
      logic [4:0] idx;
      if (bn >= 2'(BYTES_PER_FRAME - 1)) begin
         bsel = 2'd0;
      end else begin
         bsel = 2'(BYTES_PER_FRAME - 1) - bn;
      end
      idx = {bsel, ~bt};
      return frame[idx];
   endfunction

endpackage

@@ hw/rtl/oledser_front.sv @@
// ----------------------------------------------------------------------------
// oledser_front
// Accepts request transactions, decodes the operation and queues them.
// ----------------------------------------------------------------------------
module oledser_front import oledser_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output qhead_type    q_head,
   input  logic         q_pop
);

   qent_type   slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   qent_type   ent;

   always_comb begin
      ent.start_req = (req_data.operation == OP_CMD) || (req_data.operation == OP_DATA);
      ent.is_data   = (req_data.operation == OP_DATA);
      ent.payload   = req_data.payload;
   end

   assign req_ready = (count_ff != 2'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;

   assign q_head.valid = (count_ff != 2'd0);
   assign q_head.ent   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= ent;
      end
   end

endmodule

@@ hw/rtl/oledser_back.sv @@
// ----------------------------------------------------------------------------
// oledser_back
// Line sequencer: one tick per queued transaction, result held in an
// output register until taken.
// ----------------------------------------------------------------------------
module oledser_back import oledser_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic          csr_index,
   input  logic [7:0]    csr_write_data,
   input  qhead_type     q_head,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_data_type  rsp_data
);

   typedef enum logic [9:0] {
      PH_IDLE       = 10'b00_0000_0001,
      PH_START_HIGH = 10'b00_0000_0010,
      PH_START_FALL = 10'b00_0000_0100,
      PH_BIT_LOW    = 10'b00_0000_1000,
      PH_BIT_HIGH   = 10'b00_0001_0000,
      PH_ACK_LOW    = 10'b00_0010_0000,
      PH_ACK_HIGH   = 10'b00_0100_0000,
      PH_STOP_LOW   = 10'b00_1000_0000,
      PH_STOP_RISE  = 10'b01_0000_0000,
      PH_STOP_END   = 10'b10_0000_0000
   } phase_type;

   logic [7:0]         dev_addr_ff;
   logic [7:0]         delay_ff;
   phase_type          phase_ff, phase_in;
   logic [1:0]         byte_ff, byte_in;
   logic [2:0]         bit_ff, bit_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [7:0]         wait_ff, wait_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_ff, rsp_in;
   logic               step;
   logic [7:0]         load;
   logic [7:0]         wdec;
   logic               rej;
   logic               done;

   // advance when a tick is queued and the output slot frees up this cycle
   assign step  = q_head.valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop = step;
   assign load  = (delay_ff == 8'd0) ? 8'd1 : delay_ff;
   assign wdec  = (wait_ff != 8'd0) ? wait_ff - 8'd1 : 8'd0;

   always_comb begin
      phase_in = phase_ff;
      byte_in  = byte_ff;
      bit_in   = bit_ff;
      frame_in = frame_ff;
      wait_in  = wait_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      rej      = 1'b0;
      done     = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (q_head.ent.start_req) begin
            frame_in = {dev_addr_ff, q_head.ent.is_data ? CTRL_DATA : CTRL_CMD,
                        q_head.ent.payload};
            byte_in  = 2'd0;
            bit_in   = 3'd0;
            phase_in = PH_START_HIGH;
            scl_in   = 1'b1;
            sda_in   = 1'b1;
            wait_in  = load;
         end
      end else begin
         rej     = q_head.ent.start_req;
         wait_in = wdec;
         if (wdec == 8'd0) begin
            wait_in = load;
            unique case (phase_ff)
               PH_START_HIGH: begin
                  phase_in = PH_START_FALL;
                  scl_in   = 1'b1;
                  sda_in   = 1'b0;
               end
               PH_START_FALL: begin
                  phase_in = PH_BIT_LOW;
                  scl_in   = 1'b0;
                  sda_in   = frame_bit(frame_ff, byte_ff, bit_ff);
               end
               PH_BIT_LOW: begin
                  phase_in = PH_BIT_HIGH;
                  scl_in   = 1'b1;
               end
               PH_BIT_HIGH: begin
                  if (bit_ff == 3'd7) begin
                     bit_in   = 3'd0;
                     phase_in = PH_ACK_LOW;
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                  end else begin
                     bit_in   = bit_ff + 3'd1;
                     phase_in = PH_BIT_LOW;
                     scl_in   = 1'b0;
                     sda_in   = frame_bit(frame_ff, byte_ff, bit_ff + 3'd1);
                  end
               end
               PH_ACK_LOW: begin
                  phase_in = PH_ACK_HIGH;
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
               end
               PH_ACK_HIGH: begin
                  if (byte_ff >= 2'(BYTES_PER_FRAME - 1)) begin
                     phase_in = PH_STOP_LOW;
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                  end else begin
                     byte_in  = byte_ff + 2'd1;
                     bit_in   = 3'd0;
                     phase_in = PH_BIT_LOW;
                     scl_in   = 1'b0;
                     sda_in   = frame_bit(frame_ff, byte_ff + 2'd1, 3'd0);
                  end
               end
               PH_STOP_LOW: begin
                  phase_in = PH_STOP_RISE;
                  scl_in   = 1'b1;
                  sda_in   = 1'b0;
               end
               PH_STOP_RISE: begin
                  phase_in = PH_STOP_END;
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
               end
               PH_STOP_END: begin
                  phase_in = PH_IDLE;
                  wait_in  = 8'd0;
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  done     = 1'b1;
               end
               default: begin
                  phase_in = PH_IDLE;
                  wait_in  = 8'd0;
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_in.scl_level = scl_in;
      rsp_in.sda_level = sda_in;
      rsp_in.busy_res  = (phase_in != PH_IDLE);
      rsp_in.done_res  = done;
      rsp_in.rejected  = rej;
      rsp_valid_in     = step || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff  <= ADDR_RESET;
         delay_ff     <= DELAY_RESET;
         phase_ff     <= PH_IDLE;
         byte_ff      <= 2'd0;
         bit_ff       <= 3'd0;
         frame_ff     <= '0;
         wait_ff      <= 8'd0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DEVICE_ADDRESS: dev_addr_ff <= csr_write_data;
               CSR_DELAY_TICKS:    delay_ff    <= csr_write_data;
               default:            ;
            endcase
         end
         if (step) begin
            phase_ff <= phase_in;
            byte_ff  <= byte_in;
            bit_ff   <= bit_in;
            frame_ff <= frame_in;
            wait_ff  <= wait_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // done and busy never show together
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.done_res && rsp_ff.busy_res))
      else $error("done reported while busy");

   // idle sequencer holds no pending delay
   a_idle_wait_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (wait_ff == 8'd0))
      else $error("wait count left over in idle");

   // phase holds while the delay still runs
   a_hold_in_delay: assert property (@(posedge clock) disable iff (reset)
      (step && (phase_ff != PH_IDLE) && (wait_ff > 8'd1)) |=> $stable(phase_ff))
      else $error("phase moved before delay elapsed");

   // a start from idle always opens with the start-high segment
   a_start_entry: assert property (@(posedge clock) disable iff (reset)
      (step && (phase_ff == PH_IDLE) && q_head.ent.start_req)
         |=> (phase_ff == PH_START_HIGH))
      else $error("start did not enter start-high");

   // rejection only reported for a step taken mid-transaction
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      (step && (phase_ff == PH_IDLE)) |=> !rsp_ff.rejected)
      else $error("request rejected while idle");

endmodule

@@ hw/rtl/oled_i2c_write_serializer_unit.sv @@
// ----------------------------------------------------------------------------
// oled_i2c_write_serializer_unit
// Write-only I2C master for an OLED display controller, stepped by ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Each req_ transaction is one tick of the line sequencer. operation picks
//   tick only, start command write (control 0x00) or start data write
//   (control 0x40); payload is latched when a start is taken from idle.
//   Every tick yields exactly one rsp_ transaction carrying the SCL/SDA
//   levels after that tick plus busy, done and rejected flags.
//   A frame is: start, device address, control byte, payload (MSB first,
//   one unsampled ACK clock after each byte), stop. Every line segment lasts
//   delay_ticks ticks (0 behaves as 1).
//   csr_ writes set device_address (index 0) and delay_ticks (index 1); they
//   must be made only while no tick is in flight; the block does not enforce it.
// Timing:
//   A tick is written into the two-entry front queue, then lands in the
//   sequencer output register that drives rsp_valid and rsp_data.
//   Throughput is one tick per cycle while rsp_ready does not hold the result.
// Reset: lines released high, sequencer idle, queue and output empty,
//   registers back to 0x78 and 10.
// Stall: when rsp_ready is low the result holds; the queue keeps taking
//   ticks until its two entries are full, then req_ready drops.
// ----------------------------------------------------------------------------
module oled_i2c_write_serializer_unit import oledser_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data,
   input  logic         csr_write_enable,
   input  logic         csr_index,
   input  logic [7:0]   csr_write_data
);

   qhead_type q_head;
   logic      q_pop;

   // front end: decode and buffer ticks
   oledser_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   // back end: line sequencer and result register
   oledser_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the OLED I2C write serializer unit.
// Every tick sent on req_ is run through a local model of the line
// sequencer. Each rsp_ transaction is compared field by field with the
// oldest prediction. Directed tests cover the address extremes, zero and
// unit delay, refused starts and the unused opcode. Random frames then run
// under three handshake idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
   import oledser_pkg::*;

   // sequencer segments, in frame order
   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_START_HIGH,
      SEQ_START_FALL,
      SEQ_BIT_LOW,
      SEQ_BIT_HIGH,
      SEQ_ACK_LOW,
      SEQ_ACK_HIGH,
      SEQ_STOP_LOW,
      SEQ_STOP_RISE,
      SEQ_STOP_END
   } seq_phase_type;

   localparam int RANDOM_TICKS  = 600;
   localparam int DRAIN_CYCLES  = 4;
   localparam int TIMEOUT_UNITS = 10_000_000;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_data_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_data_type rsp_data;
   logic         csr_write_enable;
   logic         csr_index;
   logic [7:0]   csr_write_data;

   // register copies
   logic [7:0]   cfg_address;
   logic [7:0]   cfg_delay;

   // line sequencer copy
   seq_phase_type       seq_phase;
   logic [1:0]          seq_byte;
   logic [2:0]          seq_bit;
   logic [FRAME_W-1:0]  seq_frame;
   logic [7:0]          seq_wait;
   logic                seq_scl;
   logic                seq_sda;

   rsp_data_type expected_lines[$];

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int frames_done   = 0;
   int starts_refused = 0;
   int error_count   = 0;

   oled_i2c_write_serializer_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Line sequencer prediction
   // ------------------------------------------------------------------------

   // each segment holds for delay ticks; zero delay behaves as one
   function automatic void enter_segment(input seq_phase_type ph, input logic scl,
                                         input logic sda);
      seq_phase = ph;
      seq_scl   = scl;
      seq_sda   = sda;
      seq_wait  = (cfg_delay == 8'd0) ? 8'd1 : cfg_delay;
   endfunction

   // frame is {address, control, payload}, each byte MSB first
   function automatic logic next_bit();
      int pos;
      pos = 8 * (BYTES_PER_FRAME - 1 - int'(seq_byte)) + 7 - int'(seq_bit);
      return seq_frame[pos];
   endfunction

   function automatic rsp_data_type advance_sequencer(input req_data_type item);
      rsp_data_type r;
      logic         start_req;
      logic [7:0]   ctrl;
      r = '0;
      start_req = (item.operation == OP_CMD) || (item.operation == OP_DATA);
      if (seq_phase == SEQ_IDLE) begin
         if (start_req) begin
            ctrl      = (item.operation == OP_DATA) ? CTRL_DATA : CTRL_CMD;
            seq_frame = {cfg_address, ctrl, item.payload};
            seq_byte  = 2'd0;
            seq_bit   = 3'd0;
            enter_segment(SEQ_START_HIGH, 1'b1, 1'b1);
         end
      end else begin
         // a start while busy is dropped but the tick still counts
         r.rejected = start_req;
         if (seq_wait != 8'd0) seq_wait = seq_wait - 8'd1;
         if (seq_wait == 8'd0) begin
            case (seq_phase)
               SEQ_START_HIGH: enter_segment(SEQ_START_FALL, 1'b1, 1'b0);
               SEQ_START_FALL: enter_segment(SEQ_BIT_LOW, 1'b0, next_bit());
               SEQ_BIT_LOW:    enter_segment(SEQ_BIT_HIGH, 1'b1, seq_sda);
               SEQ_BIT_HIGH: begin
                  if (seq_bit == 3'd7) begin
                     seq_bit = 3'd0;
                     enter_segment(SEQ_ACK_LOW, 1'b0, 1'b1);
                  end else begin
                     seq_bit = seq_bit + 3'd1;
                     enter_segment(SEQ_BIT_LOW, 1'b0, next_bit());
                  end
               end
               SEQ_ACK_LOW:    enter_segment(SEQ_ACK_HIGH, 1'b1, 1'b1);
               SEQ_ACK_HIGH: begin
                  if (int'(seq_byte) + 1 >= BYTES_PER_FRAME) begin
                     enter_segment(SEQ_STOP_LOW, 1'b0, 1'b0);
                  end else begin
                     seq_byte = seq_byte + 2'd1;
                     seq_bit  = 3'd0;
                     enter_segment(SEQ_BIT_LOW, 1'b0, next_bit());
                  end
               end
               SEQ_STOP_LOW:   enter_segment(SEQ_STOP_RISE, 1'b1, 1'b0);
               SEQ_STOP_RISE:  enter_segment(SEQ_STOP_END, 1'b1, 1'b1);
               default: begin
                  // end of stop, or a phase that should never occur
                  r.done_res = (seq_phase == SEQ_STOP_END);
                  seq_phase  = SEQ_IDLE;
                  seq_wait   = 8'd0;
                  seq_scl    = 1'b1;
                  seq_sda    = 1'b1;
               end
            endcase
         end
      end
      r.scl_level = seq_scl;
      r.sda_level = seq_sda;
      r.busy_res  = (seq_phase != SEQ_IDLE);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t result %0d: %s", $time, results_seen, what);
      error_count++;
   endtask

   // sampled at the rising edge, before any update from that edge lands
   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_lines.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            want = expected_lines.pop_front();
            if (rsp_data.scl_level !== want.scl_level)
               report_mismatch($sformatf("scl_level %b, expected %b",
                                         rsp_data.scl_level, want.scl_level));
            if (rsp_data.sda_level !== want.sda_level)
               report_mismatch($sformatf("sda_level %b, expected %b",
                                         rsp_data.sda_level, want.sda_level));
            if (rsp_data.busy_res !== want.busy_res)
               report_mismatch($sformatf("busy_res %b, expected %b",
                                         rsp_data.busy_res, want.busy_res));
            if (rsp_data.done_res !== want.done_res)
               report_mismatch($sformatf("done_res %b, expected %b",
                                         rsp_data.done_res, want.done_res));
            if (rsp_data.rejected !== want.rejected)
               report_mismatch($sformatf("rejected %b, expected %b",
                                         rsp_data.rejected, want.rejected));
            if (want.done_res) frames_done++;
            if (want.rejected) starts_refused++;
         end
         results_seen++;
      end
   end

   // receiver backpressure; changes only on the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers. All of them start and end just after a falling edge.
   // ------------------------------------------------------------------------

   function automatic req_data_type req_item(input op_type op, input logic [7:0] pl);
      req_data_type t;
      t.operation = op;
      t.payload   = pl;
      return t;
   endfunction

   // one tick transaction; valid is left high so back-to-back ticks stream
   task automatic send_tick(input req_data_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      expected_lines.push_back(advance_sequencer(item));
      items_sent++;
      @(negedge clock);
   endtask

   // hold the sender off until every predicted result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_lines.size() != 0) @(negedge clock);
   endtask

   // registers change only with nothing in flight and the sequencer idle
   task automatic configure(input logic [7:0] addr, input logic [7:0] delay);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DEVICE_ADDRESS;
      csr_write_data   <= addr;
      @(negedge clock);
      csr_index        <= CSR_DELAY_TICKS;
      csr_write_data   <= delay;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cfg_address = addr;
      cfg_delay   = delay;
      @(negedge clock);
   endtask

   // tick until the frame is over; with noise, some ticks carry a start
   // (refused while busy) or the unused opcode
   task automatic run_to_idle(input bit noise);
      int   pick;
      op_type op;
      while (seq_phase != SEQ_IDLE) begin
         pick = $urandom_range(99);
         op   = OP_TICK;
         if (noise && pick < 5) op = OP_CMD;
         else if (noise && pick < 10) op = OP_DATA;
         else if (noise && pick < 15) op = OP_UNUSED;
         send_tick(req_item(op, 8'($urandom)));
      end
   endtask

   // tick up to the last stop step, then land a start right on it
   task automatic refuse_on_final_step(input op_type op);
      while (!(seq_phase == SEQ_STOP_END && seq_wait == 8'd1))
         send_tick(req_item(OP_TICK, 8'($urandom)));
      send_tick(req_item(op, 8'($urandom)));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // reset register values, idle ticks, unused opcode, a refused start
   task automatic test_reset_defaults();
      send_tick(req_item(OP_TICK, 8'h00));
      send_tick(req_item(OP_UNUSED, 8'hFF));
      send_tick(req_item(OP_CMD, 8'hA5));
      send_tick(req_item(OP_DATA, 8'h5A));     // busy: refused
      send_tick(req_item(OP_UNUSED, 8'h00));   // busy: just a tick
      run_to_idle(1'b0);
   endtask

   // zero delay acts as one; starts refused on the completing step;
   // a start right after done is taken
   task automatic test_short_delays();
      configure(8'h00, 8'd0);
      send_tick(req_item(OP_DATA, 8'hFF));
      refuse_on_final_step(OP_CMD);
      send_tick(req_item(OP_CMD, 8'h00));
      refuse_on_final_step(OP_DATA);
      configure(8'hFF, 8'd1);
      send_tick(req_item(OP_DATA, 8'h00));
      send_tick(req_item(OP_CMD, 8'hFF));
      run_to_idle(1'b0);
      send_tick(req_item(OP_CMD, 8'h80));
      run_to_idle(1'b0);
   endtask

   // random frames under each handshake idling mix, with a new
   // address and delay every few frames
   task automatic test_random_frames();
      int         mode;
      int         mode_start;
      logic [7:0] delay;
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle_pct = 22; rsp_idle_pct = 58; end
            1: begin send_idle_pct = 58; rsp_idle_pct = 22; end
            default: begin send_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         mode_start = items_sent;
         while (items_sent - mode_start < RANDOM_TICKS / 3) begin
            case ($urandom_range(9))
               0:       delay = 8'd0;
               1:       delay = 8'($urandom_range(4, 8));
               default: delay = 8'($urandom_range(1, 3));
            endcase
            configure(8'($urandom), delay);
            repeat (3) begin
               // a few idle ticks, then a well-formed frame with noise in it
               repeat ($urandom_range(0, 2))
                  send_tick(req_item($urandom_range(1) ? OP_TICK : OP_UNUSED,
                                     8'($urandom)));
               send_tick(req_item($urandom_range(1) ? OP_CMD : OP_DATA,
                                  8'($urandom)));
               if ($urandom_range(4) == 0) refuse_on_final_step(OP_DATA);
               else run_to_idle(1'b1);
               if ($urandom_range(3) == 0) wait_for_results();
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_DEVICE_ADDRESS;
      csr_write_data   = 8'h00;
      cfg_address      = ADDR_RESET;
      cfg_delay        = DELAY_RESET;
      seq_phase        = SEQ_IDLE;
      seq_byte         = 2'd0;
      seq_bit          = 3'd0;
      seq_frame        = '0;
      seq_wait         = 8'd0;
      seq_scl          = 1'b1;
      seq_sda          = 1'b1;
      send_idle_pct    = 22;
      rsp_idle_pct     = 58;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_short_delays();
      test_random_frames();

      wait_for_results();
      repeat (DRAIN_CYCLES * 2) @(negedge clock);
      if (expected_lines.size() != 0)
         report_mismatch("expected results left over");

      $display("Run: %0d ticks sent, %0d results checked, %0d frames completed,",
               items_sent, results_seen, frames_done);
      $display("     %0d busy starts refused; delays 0 to 10, addresses 0x00-0xFF.",
               starts_refused);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_UNITS);
      $display("Timeout: %0d ticks sent, %0d results outstanding",
               items_sent, expected_lines.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/oledser_pkg.sv
hw/rtl/oledser_front.sv
hw/rtl/oledser_back.sv
hw/rtl/oled_i2c_write_serializer_unit.sv
tb/tb_top.sv
